// ----- hdl/pit_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic interrupt timer package
// Field widths, register map and shared types of the periodic interrupt timer.
// ----------------------------------------------------------------------------
package pit_pkg;

  // Item and result field widths.
  localparam int unsigned CyclesW = 8;
  localparam int unsigned VectorW = 8;
  localparam int unsigned LevelW  = 3;
  localparam int unsigned ModW    = 8;

  // Accumulator and period width.
  localparam int unsigned AccW    = 32;

  // Configuration bus.
  localparam int unsigned DataW   = 32;
  localparam int unsigned AddrW   = 4;

  // Period scaling: a modulus unit is four reference clocks of a 32768 Hz
  // reference, so the period is modulus * CPU_CLOCK_HZ / 8192 without the
  // prescaler and modulus * CPU_CLOCK_HZ / 16 with it.
  localparam int unsigned ShiftPlain    = 13;
  localparam int unsigned ShiftPrescale = 4;

  // Register indexes (byte address divided by four).
  typedef enum logic [1:0] {
    REG_TIMER_MODULUS     = 2'd0,
    REG_PRESCALE_ENABLE   = 2'd1,
    REG_IRQ_PRIORITY      = 2'd2,
    REG_IRQ_VECTOR_NUMBER = 2'd3
  } reg_index_t;

  typedef logic [CyclesW-1:0] cycles_t;
  typedef logic [VectorW-1:0] vector_t;
  typedef logic [LevelW-1:0]  level_t;
  typedef logic [ModW-1:0]    modulus_t;
  typedef logic [AccW-1:0]    acc_t;

endpackage
`default_nettype wire

// ----- hdl/pit_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic interrupt timer channels
// Valid/ready channels for the tick items and the interrupt results.
// ----------------------------------------------------------------------------

// Tick item channel: the elapsed_cycles field and the pending flag.
interface pit_item_if;
  logic                    valid;
  logic                    ready;
  pit_pkg::cycles_t        elapsed_cycles;
  logic                    already_pending;

  modport source (output valid, output elapsed_cycles, output already_pending,
                  input ready);
  modport sink   (input valid, input elapsed_cycles, input already_pending,
                  output ready);
endinterface

// Result channel: interrupt request raised for one tick item.
interface pit_result_if;
  logic                    valid;
  logic                    ready;
  logic                    raise_irq;
  pit_pkg::vector_t        out_vector;
  pit_pkg::level_t         out_level;

  modport source (output valid, output raise_irq, output out_vector,
                  output out_level, input ready);
  modport sink   (input valid, input raise_irq, input out_vector,
                  input out_level, output ready);
endinterface
`default_nettype wire

// ----- hdl/periodic_interrupt_timer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: each item passes through the input register, then the result
// register, from which its result is offered on the result channel.
// Throughput: one item per cycle while results are taken; the accumulator
// add, compare and subtract sit between the input and result registers.
// Reset: synchronous, active high; clears the configuration and period registers,
// the accumulator and both pipeline valid flags.
// ----------------------------------------------------------------------------
// Periodic interrupt timer
// Accumulates the elapsed time of each tick item and raises an interrupt request each time
// the programmed period is reached, unless a request is already pending.
// ----------------------------------------------------------------------------
module periodic_interrupt_timer #(
  parameter int unsigned CPU_CLOCK_HZ = 16777216
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  pit_item_if.sink                        item,
  pit_result_if.source                    result,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pit_pkg::AddrW-1:0]  paddr,
  input  wire logic [pit_pkg::DataW-1:0]  pwdata,
  output logic      [pit_pkg::DataW-1:0]  prdata,
  output logic                            pready
);

  localparam int unsigned ProdW = pit_pkg::ModW + pit_pkg::AccW;
  localparam logic [pit_pkg::AccW-1:0] ClockHz = pit_pkg::AccW'(CPU_CLOCK_HZ);

  // Configuration registers.
  pit_pkg::modulus_t timer_modulus;
  logic              prescale_enable;
  pit_pkg::level_t   irq_priority;
  pit_pkg::vector_t  irq_vector_number;

  pit_pkg::reg_index_t reg_sel;
  logic                cfg_write;

  // Period register and accumulator.
  logic [ProdW-1:0]  period_prod;
  pit_pkg::acc_t     period;
  pit_pkg::acc_t     period_next;
  pit_pkg::acc_t     cycle_accumulator;
  pit_pkg::acc_t     acc_sum;
  logic              timer_enable;
  logic              period_reached;

  // Input stage.
  logic              in_valid;
  pit_pkg::cycles_t  in_cycles;
  logic              in_pending;

  // Result stage.
  logic              res_valid;
  logic              res_raise;
  pit_pkg::vector_t  res_vector;
  pit_pkg::level_t   res_level;

  logic              res_advance;
  logic              in_advance;

  // Register access decode; the bus never waits.
  assign reg_sel   = pit_pkg::reg_index_t'(paddr[pit_pkg::AddrW-1:2]);
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_modulus     <= '0;
      prescale_enable   <= 1'b0;
      irq_priority      <= '0;
      irq_vector_number <= '0;
    end else if (cfg_write) begin
      case (reg_sel)
        pit_pkg::REG_TIMER_MODULUS:     timer_modulus     <= pwdata[pit_pkg::ModW-1:0];
        pit_pkg::REG_PRESCALE_ENABLE:   prescale_enable   <= pwdata[0];
        pit_pkg::REG_IRQ_PRIORITY:      irq_priority      <= pwdata[pit_pkg::LevelW-1:0];
        pit_pkg::REG_IRQ_VECTOR_NUMBER: irq_vector_number <= pwdata[pit_pkg::VectorW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read back, zero extended.
  always_comb begin
    case (reg_sel)
      pit_pkg::REG_TIMER_MODULUS:     prdata = pit_pkg::DataW'(timer_modulus);
      pit_pkg::REG_PRESCALE_ENABLE:   prdata = pit_pkg::DataW'(prescale_enable);
      pit_pkg::REG_IRQ_PRIORITY:      prdata = pit_pkg::DataW'(irq_priority);
      pit_pkg::REG_IRQ_VECTOR_NUMBER: prdata = pit_pkg::DataW'(irq_vector_number);
      default:                        prdata = '0;
    endcase
  end

  // Period, scaled by the CPU clock rate and registered from the configuration registers.
  // The division by the reference clock is a right shift.
  assign period_prod = ProdW'(timer_modulus) * ProdW'(ClockHz);

  always_comb begin
    if (prescale_enable) begin
      period_next = period_prod[pit_pkg::ShiftPrescale +: pit_pkg::AccW];
    end else begin
      period_next = pit_pkg::AccW'(period_prod[ProdW-1:pit_pkg::ShiftPlain]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= '0;
    end else begin
      period <= period_next;
    end
  end

  // Pipeline flow control: the result register frees when taken, and the
  // input register frees when its item moves on.
  assign res_advance = !res_valid || result.ready;
  assign in_advance  = in_valid && res_advance;
  assign item.ready  = !in_valid || res_advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_cycles  <= item.elapsed_cycles;
      in_pending <= item.already_pending;
    end
  end

  // Accumulate and compare against the period.
  assign timer_enable   = (timer_modulus != '0) && (irq_priority != '0);
  assign acc_sum        = cycle_accumulator + pit_pkg::AccW'(in_cycles);
  assign period_reached = acc_sum >= period;

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_accumulator <= '0;
    end else if (in_advance && timer_enable) begin
      if (period_reached) begin
        cycle_accumulator <= acc_sum - period;
      end else begin
        cycle_accumulator <= acc_sum;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_advance) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance) begin
      res_raise  <= timer_enable && period_reached && !in_pending;
      if (timer_enable && period_reached && !in_pending) begin
        res_vector <= irq_vector_number;
        res_level  <= irq_priority;
      end else begin
        res_vector <= '0;
        res_level  <= '0;
      end
    end
  end

  assign result.valid      = res_valid;
  assign result.raise_irq  = res_raise;
  assign result.out_vector = res_vector;
  assign result.out_level  = res_level;

endmodule
`default_nettype wire

// ----- hdl/pit_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic interrupt timer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module pit_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             res_valid,
  input wire logic             res_ready,
  input wire logic             raise_irq,
  input wire pit_pkg::vector_t out_vector,
  input wire pit_pkg::level_t  out_level
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // A raised request never carries level zero, which disables the timer.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && raise_irq |-> out_level != '0)
    else $error("request raised at level zero");

  // Without a request, the vector and level read as zero.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !raise_irq |-> (out_vector == '0) && (out_level == '0))
    else $error("vector or level set without a request");

  // The cycle after reset shows no result.
  assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule

bind periodic_interrupt_timer pit_checker u_pit_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .raise_irq  (result.raise_irq),
  .out_vector (result.out_vector),
  .out_level  (result.out_level)
);
`default_nettype wire

// ----- sim/periodic_interrupt_timer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic interrupt timer testbench
// Sends tick transfers through the item channel and checks every result
// against a software copy of the accumulator, so that each
// raise_irq, out_vector and out_level field is compared in order. The run
// covers the disabled timer, periods reached while a request is pending,
// shortened periods, long plain and prescaled periods, random settings and a
// long result stall.
// ----------------------------------------------------------------------------
module periodic_interrupt_timer_tb;

  localparam int unsigned CpuClockHz    = 16777216;
  localparam int unsigned RefClockHz    = 32768;
  localparam int unsigned TicksPerUnit  = 4;
  localparam int unsigned PrescaleRatio = 512;
  localparam int          LongStall     = 80;
  localparam int          WatchdogLimit = 2000;
  localparam int          DrainCycles   = 8;
  localparam int          IdleCycles    = 4;
  localparam int          ReportLimit   = 10;

  // One interrupt request as the block reports it for a tick.
  typedef struct packed {
    logic             raise;
    pit_pkg::vector_t vector;
    pit_pkg::level_t  level;
  } irq_req_t;

  logic clk;
  logic rst;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [pit_pkg::AddrW-1:0] paddr;
  logic [pit_pkg::DataW-1:0] pwdata;
  logic [pit_pkg::DataW-1:0] prdata;
  logic                      pready;

  pit_item_if   item_ch();
  pit_result_if result_ch();

  periodic_interrupt_timer #(
    .CPU_CLOCK_HZ(CpuClockHz)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Shadow copy of the registers and the accumulator.
  pit_pkg::modulus_t cfg_modulus;
  logic              cfg_prescale;
  pit_pkg::level_t   cfg_level;
  pit_pkg::vector_t  cfg_vector;
  pit_pkg::acc_t     acc_model;

  irq_req_t upcoming_requests[$];

  int   mismatches;
  int   n_ticks;
  int   n_results;
  int   n_raised;
  int   n_writes;
  logic quiet_mode;
  int   stalls_asked;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    if (quiet_mode) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Timer period for the current settings, scaled by the CPU clock rate.
  function automatic logic [63:0] period_cycles();
    logic [63:0] p;
    p = 64'(cfg_modulus) * TicksPerUnit;
    if (cfg_prescale) p = p * PrescaleRatio;
    return p * 64'(CpuClockHz) / 64'(RefClockHz);
  endfunction

  // Advance the accumulator by one tick and work out the request it raises.
  function automatic irq_req_t advance_timer(pit_pkg::cycles_t cycles, logic pend);
    irq_req_t req;
    logic [63:0] period;
    req = '0;
    if (cfg_modulus == '0 || cfg_level == '0) return req;
    period = period_cycles();
    acc_model = acc_model + pit_pkg::acc_t'(cycles);
    if ({32'b0, acc_model} < period) return req;
    acc_model = acc_model - period[pit_pkg::AccW-1:0];
    if (!pend) begin
      req.raise  = 1'b1;
      req.vector = cfg_vector;
      req.level  = cfg_level;
    end
    return req;
  endfunction

  // Offer one tick after a random gap and record its request once accepted.
  task automatic send_tick(input pit_pkg::cycles_t cycles, input logic pend);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid           <= 1'b1;
    item_ch.elapsed_cycles  <= cycles;
    item_ch.already_pending <= pend;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    upcoming_requests = {upcoming_requests, advance_timer(cycles, pend)};
    n_ticks++;
  endtask

  // Stop offering and let every outstanding result drain out.
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (upcoming_requests.size() != 0) @(posedge clk);
    repeat (IdleCycles) @(posedge clk);
  endtask

  // One register write; bits above the field width carry random junk.
  task automatic write_reg(input pit_pkg::reg_index_t idx,
                           input logic [pit_pkg::DataW-1:0] value);
    logic [pit_pkg::DataW-1:0] data;
    data = $urandom();
    case (idx)
      pit_pkg::REG_TIMER_MODULUS:
        data[pit_pkg::ModW-1:0] = value[pit_pkg::ModW-1:0];
      pit_pkg::REG_PRESCALE_ENABLE:
        data[0] = value[0];
      pit_pkg::REG_IRQ_PRIORITY:
        data[pit_pkg::LevelW-1:0] = value[pit_pkg::LevelW-1:0];
      pit_pkg::REG_IRQ_VECTOR_NUMBER:
        data[pit_pkg::VectorW-1:0] = value[pit_pkg::VectorW-1:0];
      default: ;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= pit_pkg::AddrW'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      pit_pkg::REG_TIMER_MODULUS:     cfg_modulus  = data[pit_pkg::ModW-1:0];
      pit_pkg::REG_PRESCALE_ENABLE:   cfg_prescale = data[0];
      pit_pkg::REG_IRQ_PRIORITY:      cfg_level    = data[pit_pkg::LevelW-1:0];
      pit_pkg::REG_IRQ_VECTOR_NUMBER: cfg_vector   = data[pit_pkg::VectorW-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  // Program all four registers once the block has gone idle.
  task automatic configure(input int modulus, input int prescale, input int level,
                           input int vector);
    wait_idle();
    write_reg(pit_pkg::REG_TIMER_MODULUS, pit_pkg::DataW'(modulus));
    write_reg(pit_pkg::REG_PRESCALE_ENABLE, pit_pkg::DataW'(prescale));
    write_reg(pit_pkg::REG_IRQ_PRIORITY, pit_pkg::DataW'(level));
    write_reg(pit_pkg::REG_IRQ_VECTOR_NUMBER, pit_pkg::DataW'(vector));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Zero modulus or zero level must give empty results and leave the
  // accumulator alone.
  task automatic check_disabled_timer();
    send_tick(8'd0, 1'b0);
    send_tick(8'd255, 1'b1);
    send_tick(8'd255, 1'b0);
    send_tick(8'd1, 1'b0);
    send_tick(8'd128, 1'b1);
    send_tick(8'd127, 1'b0);
    configure(5, 0, 0, 8'hAA);
    send_tick(8'd255, 1'b0);
    send_tick(8'd255, 1'b0);
    send_tick(8'd64, 1'b1);
    configure(0, 1, 7, 8'h55);
    send_tick(8'd255, 1'b0);
    send_tick(8'd0, 1'b0);
    send_tick(8'd170, 1'b1);
  endtask

  // Shortest plain period: one firing swallowed by a pending request, one
  // raised with the top level and vector.
  task automatic check_first_periods();
    configure(1, 0, 7, 8'hFF);
    repeat (8) send_tick(8'd255, 1'b0);
    send_tick(8'd0, 1'b0);
    send_tick(8'd8, 1'b1);
    repeat (9) send_tick(8'd255, 1'b0);
  endtask

  // Fill the accumulator under a long period, then shorten the period so the
  // timer fires on many consecutive ticks, one period at a time.
  task automatic check_shortened_period();
    configure(255, 0, 1, 8'h00);
    repeat (100)
      send_tick(pit_pkg::cycles_t'($urandom_range(128, 255)),
                1'($urandom_range(0, 1)));
    configure(1, 0, 1, 8'h00);
    repeat (30) send_tick(8'd0, 1'($urandom_range(0, 3) == 0));
  endtask

  // Longest plain period: the accumulator only grows.
  task automatic check_longest_period();
    configure(255, 0, 7, $urandom_range(0, 255));
    repeat (40) send_tick(pit_pkg::cycles_t'(255 - $urandom_range(0, 15)), 1'b0);
  endtask

  // Prescaler on the shortest modulus keeps the timer quiet; the random
  // phases that follow start from the grown accumulator.
  task automatic check_prescaler();
    configure(1, 1, 3, $urandom_range(0, 255));
    repeat (40) send_tick(pit_pkg::cycles_t'(255 - $urandom_range(0, 15)), 1'b0);
  endtask

  // Random settings and random ticks, one phase per setting.
  task automatic check_random_settings();
    int modulus;
    int prescale;
    int level;
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(0, 7))
        0:       modulus = 0;
        1:       modulus = 255;
        default: modulus = $urandom_range(1, 6);
      endcase
      prescale = ($urandom_range(0, 7) == 0);
      level    = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 7);
      configure(modulus, prescale, level, $urandom_range(0, 255));
      quiet_mode = (phase == 3);
      for (int k = 0; k < 15; k++) begin
        if ($urandom_range(0, 1))
          send_tick(pit_pkg::cycles_t'($urandom_range(192, 255)),
                    1'($urandom_range(0, 3) == 0));
        else
          send_tick(pit_pkg::cycles_t'($urandom()), 1'($urandom_range(0, 3) == 0));
      end
    end
    quiet_mode = 1'b0;
  endtask

  // The result side holds off for a long stretch while ticks keep coming, so
  // the block fills up and pushes back on its input.
  task automatic check_result_stall();
    configure(1, 0, 2, $urandom_range(0, 255));
    quiet_mode   = 1'b1;
    stalls_asked <= stalls_asked + 1;
    repeat (60) send_tick(pit_pkg::cycles_t'($urandom()), 1'($urandom_range(0, 3) == 0));
    quiet_mode = 1'b0;
  endtask

  // Result side ready: random holds, plus the long stall when asked for.
  initial begin : result_ready_ctl
    int hold_left;
    int stalls_done;
    hold_left   = 0;
    stalls_done = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
      end else if (stalls_done != stalls_asked) begin
        stalls_done++;
        hold_left = LongStall;
      end else if ($urandom_range(0, 2) == 0) begin
        hold_left = pick_gap();
      end
      result_ch.ready <= (hold_left == 0);
    end
  end

  // Compare each result transfer with the oldest predicted request.
  always @(posedge clk) begin
    irq_req_t want;
    irq_req_t got;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      got = '{raise: result_ch.raise_irq, vector: result_ch.out_vector,
              level: result_ch.out_level};
      n_results++;
      if (got.raise === 1'b1) n_raised++;
      if (upcoming_requests.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("%0t: unexpected result raise=%0b vector=%0d level=%0d",
                   $realtime, got.raise, got.vector, got.level);
      end else begin
        want = upcoming_requests.pop_front();
        if (got.raise !== want.raise || got.vector !== want.vector ||
            got.level !== want.level) begin
          mismatches++;
          // Fields are shown as raise/vector/level.
          if (mismatches <= ReportLimit)
            $display("%0t: result %0d: expected %0b/%0d/%0d, got %0b/%0d/%0d",
                     $realtime, n_results, want.raise, want.vector, want.level,
                     got.raise, got.vector, got.level);
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
          (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) ||
          (psel === 1'b1 && penable === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Watchdog expired after %0d idle cycles", quiet_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Reset, the test sequence, drain and verdict.
  initial begin : stimulus
    mismatches   = 0;
    n_ticks      = 0;
    n_results    = 0;
    n_raised     = 0;
    n_writes     = 0;
    cfg_modulus  = '0;
    cfg_prescale = 1'b0;
    cfg_level    = '0;
    cfg_vector   = '0;
    acc_model    = '0;
    quiet_mode   = 1'b0;
    rst                     <= 1'b1;
    item_ch.valid           <= 1'b0;
    item_ch.elapsed_cycles  <= '0;
    item_ch.already_pending <= 1'b0;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    stalls_asked            <= 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    check_disabled_timer();
    check_first_periods();
    check_shortened_period();
    check_longest_period();
    check_prescaler();
    check_random_settings();
    check_result_stall();

    // Let the last results drain, then look for anything still owed.
    item_ch.valid <= 1'b0;
    while (upcoming_requests.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (upcoming_requests.size() != 0) begin
      $display("%0d predicted results never arrived", upcoming_requests.size());
      mismatches += upcoming_requests.size();
    end

    $display("Ran %0d tick transfers and %0d register writes; %0d results checked.",
             n_ticks, n_writes, n_results);
    $display("%0d requests raised over disabled, pending, shortened, long, prescaled, %s",
             n_raised, "random and stalled phases.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/pit_pkg.sv
hdl/pit_if.sv
hdl/periodic_interrupt_timer.sv
hdl/pit_checker.sv
sim/periodic_interrupt_timer_tb.sv
